### src/gcb_pkg.sv
`default_nettype none
package gcb_pkg;

	localparam logic [31:0] Mask565 = 32'h07E0_F81F;

	typedef enum logic [1:0] {
		COV_1BIT = 2'd0,
		COV_2BIT = 2'd1,
		COV_4BIT = 2'd2,
		COV_8BIT = 2'd3
	} cov_mode_t;

	typedef enum logic [1:0] {
		FMT_RGB565   = 2'd0,
		FMT_RGB888   = 2'd1,
		FMT_RGBA8888 = 2'd2,
		FMT_NONE     = 2'd3
	} pix_fmt_t;

	typedef enum logic [1:0] {
		REG_TEXT_COLOR    = 2'd0,
		REG_COVERAGE_MODE = 2'd1,
		REG_PIXEL_FORMAT  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] text_color;
		cov_mode_t   coverage_mode;
		pix_fmt_t    pixel_format;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  alpha;
		logic [5:0]  w565;
		logic [15:0] color565;
		logic        write;
		logic        direct;
		logic [31:0] bg;
	} wgt_t;

	// floor(x / 255) for x up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return s[15:8];
	endfunction

	function automatic logic [15:0] to565(input logic [31:0] c);
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
		logic [7:0]  r5;
		logic [7:0]  g6;
		logic [7:0]  b5;
		r  = ({8'd0, c[31:24]} << 5) - {8'd0, c[31:24]};
		g  = ({8'd0, c[23:16]} << 6) - {8'd0, c[23:16]};
		b  = ({8'd0, c[15:8]} << 5) - {8'd0, c[15:8]};
		r5 = div255(r);
		g6 = div255(g);
		b5 = div255(b);
		return {r5[4:0], g6[5:0], b5[4:0]};
	endfunction

endpackage
`default_nettype wire

### src/gcb_in_if.sv
`default_nettype none
interface gcb_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  glyph_byte;
	logic [2:0]  sub_column;
	logic [31:0] background_pixel;

	modport source (output valid, output glyph_byte, output sub_column,
		output background_pixel, input ready);
	modport sink (input valid, input glyph_byte, input sub_column,
		input background_pixel, output ready);
endinterface
`default_nettype wire

### src/gcb_out_if.sv
`default_nettype none
interface gcb_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_out;
	logic        write_enable;

	modport source (output valid, output pixel_out, output write_enable, input ready);
	modport sink (input valid, input pixel_out, input write_enable, output ready);
endinterface
`default_nettype wire

### src/gcb_cover.sv
`default_nettype none
module gcb_cover (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire gcb_pkg::cfg_t cfg,
	gcb_in_if.sink             glyph_in,
	output logic               wgt_valid,
	input  wire logic          wgt_ready,
	output gcb_pkg::wgt_t      wgt
);
	import gcb_pkg::*;

	logic        v_s1;
	logic [15:0] prod_s1;
	logic        write_s1;
	logic        direct_s1;
	logic [31:0] bg_s1;

	logic        v_s2;
	wgt_t        wgt_s2;

	logic        rdy1;
	logic        rdy2;

	logic [7:0]  cov;
	logic [3:0]  nib;
	logic [1:0]  duo;
	logic [7:0]  ta;
	logic [7:0]  a_c;
	logic [8:0]  wsum;

	assign ta   = cfg.text_color[7:0];
	assign rdy2 = !v_s2 || wgt_ready;
	assign rdy1 = !v_s1 || rdy2;
	assign glyph_in.ready = rdy1;

	// coverage field, lsb-first, expanded to 8 bits
	always_comb begin
		duo = 2'(glyph_in.glyph_byte >> {glyph_in.sub_column[1:0], 1'b0});
		nib = glyph_in.sub_column[0] ? glyph_in.glyph_byte[7:4]
			: glyph_in.glyph_byte[3:0];
		unique case (cfg.coverage_mode)
			COV_1BIT: cov = {8{glyph_in.glyph_byte[glyph_in.sub_column]}};
			COV_2BIT: cov = {duo, duo, duo, duo};
			COV_4BIT: cov = {nib, nib};
			COV_8BIT: cov = glyph_in.glyph_byte;
			default:  cov = glyph_in.glyph_byte;
		endcase
	end

	assign a_c  = div255(prod_s1);
	assign wsum = {1'b0, a_c} + 9'd4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= glyph_in.valid;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			prod_s1   <= 16'(ta) * 16'(cov);
			write_s1  <= (cov != 8'd0) && (cfg.pixel_format != FMT_NONE);
			direct_s1 <= (cfg.coverage_mode == COV_1BIT) && (cfg.pixel_format == FMT_RGB565);
			bg_s1     <= glyph_in.background_pixel;
		end
		if (rdy2) begin
			wgt_s2.alpha    <= a_c;
			wgt_s2.w565     <= wsum[8:3];
			wgt_s2.color565 <= to565(cfg.text_color);
			wgt_s2.write    <= write_s1;
			wgt_s2.direct   <= direct_s1;
			wgt_s2.bg       <= bg_s1;
		end
	end

	assign wgt_valid = v_s2;
	assign wgt       = wgt_s2;
endmodule
`default_nettype wire

### src/gcb_mix.sv
`default_nettype none
module gcb_mix (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire gcb_pkg::cfg_t cfg,
	input  wire logic          wgt_valid,
	output logic               wgt_ready,
	input  wire gcb_pkg::wgt_t wgt,
	gcb_out_if.source          blend_out
);
	import gcb_pkg::*;

	logic        v_s3;
	logic [26:0] r565_s3;
	logic [15:0] sr_s3;
	logic [15:0] sg_s3;
	logic [15:0] sb_s3;
	logic [15:0] c565_s3;
	logic        write_s3;
	logic        direct_s3;
	logic [31:0] bg_s3;

	logic        v_s4;
	logic [31:0] pix_s4;
	logic        we_s4;

	logic        rdy3;
	logic        rdy4;

	logic [31:0] bw;
	logic [31:0] fw;
	logic [31:0] diff;
	logic [31:0] prod;
	logic [7:0]  na;
	logic [7:0]  br;
	logic [7:0]  bgn;
	logic [7:0]  bb;
	logic [31:0] b3;
	logic [31:0] r3;
	logic [31:0] pix_c;

	assign rdy4      = !v_s4 || blend_out.ready;
	assign rdy3      = !v_s3 || rdy4;
	assign wgt_ready = rdy3;

	always_comb begin
		bw   = {wgt.bg[15:0], wgt.bg[15:0]} & Mask565;
		fw   = {wgt.color565, wgt.color565} & Mask565;
		diff = fw - bw;
		prod = diff * {26'd0, wgt.w565};
		na   = 8'hFF - wgt.alpha;
		if (cfg.pixel_format == FMT_RGBA8888) begin
			br  = wgt.bg[31:24];
			bgn = wgt.bg[23:16];
			bb  = wgt.bg[15:8];
		end else begin
			br  = wgt.bg[23:16];
			bgn = wgt.bg[15:8];
			bb  = wgt.bg[7:0];
		end
	end

	// result select: background, direct 565 colour or per-format blend; 565 blend folded to 16 bits
	always_comb begin
		b3 = {bg_s3[15:0], bg_s3[15:0]} & Mask565;
		r3 = ({5'd0, r565_s3} + b3) & Mask565;
		priority if (!write_s3) begin
			pix_c = bg_s3;
		end else if (direct_s3) begin
			pix_c = {16'd0, c565_s3};
		end else begin
			unique case (cfg.pixel_format)
				FMT_RGB565:   pix_c = {16'd0, r3[31:16] | r3[15:0]};
				FMT_RGB888:   pix_c = {8'd0, div255(sr_s3), div255(sg_s3), div255(sb_s3)};
				FMT_RGBA8888: pix_c = {div255(sr_s3), div255(sg_s3), div255(sb_s3), 8'hFF};
				default:      pix_c = bg_s3;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy3) v_s3 <= wgt_valid;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			r565_s3   <= prod[31:5];
			sr_s3     <= 16'(cfg.text_color[31:24]) * 16'(wgt.alpha) + 16'(br) * 16'(na);
			sg_s3     <= 16'(cfg.text_color[23:16]) * 16'(wgt.alpha) + 16'(bgn) * 16'(na);
			sb_s3     <= 16'(cfg.text_color[15:8]) * 16'(wgt.alpha) + 16'(bb) * 16'(na);
			c565_s3   <= wgt.color565;
			write_s3  <= wgt.write;
			direct_s3 <= wgt.direct;
			bg_s3     <= wgt.bg;
		end
		if (rdy4) begin
			pix_s4 <= pix_c;
			we_s4  <= write_s3;
		end
	end

	assign blend_out.valid        = v_s4;
	assign blend_out.pixel_out    = pix_s4;
	assign blend_out.write_enable = we_s4;
endmodule
`default_nettype wire

### src/glyph_coverage_blend_top.sv
`default_nettype none
// Antialiased glyph blend: one destination pixel per transfer on glyph_in, one
// result per transfer on blend_out. Throughput is one pixel per clock while
// blend_out is ready. Each pixel passes four register stages (coverage pick and
// alpha product, weight divide, channel multiplies, divide and pack). Ready runs
// back through every stage, so while a result is stalled new pixels keep entering
// only until all four stages hold data; after that glyph_in waits until blend_out
// takes the result. Configuration (text_color, coverage_mode, pixel_format) is to
// be written through cfg_write/cfg_index/cfg_data only while the pipeline is
// empty; the block does not enforce this. Index 3 is ignored.
module glyph_coverage_blend_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	gcb_in_if.sink           glyph_in,
	gcb_out_if.source        blend_out
);
	import gcb_pkg::*;

	cfg_t cfg_q;
	logic wgt_valid;
	logic wgt_ready;
	wgt_t wgt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_color    <= 32'd0;
			cfg_q.coverage_mode <= COV_8BIT;
			cfg_q.pixel_format  <= FMT_RGB565;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_TEXT_COLOR:    cfg_q.text_color    <= cfg_data;
				REG_COVERAGE_MODE: cfg_q.coverage_mode <= cov_mode_t'(cfg_data[1:0]);
				REG_PIXEL_FORMAT:  cfg_q.pixel_format  <= pix_fmt_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	gcb_cover u_cover (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.glyph_in  (glyph_in),
		.wgt_valid (wgt_valid),
		.wgt_ready (wgt_ready),
		.wgt       (wgt)
	);

	gcb_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.wgt_valid (wgt_valid),
		.wgt_ready (wgt_ready),
		.wgt       (wgt),
		.blend_out (blend_out)
	);

	a_no_write_unassigned: assert property (@(posedge clk) disable iff (!arst_n)
		blend_out.valid && cfg_q.pixel_format == FMT_NONE |-> !blend_out.write_enable)
		else $error("write flagged for unassigned format");

	a_rgba_alpha_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		blend_out.valid && blend_out.write_enable && cfg_q.pixel_format == FMT_RGBA8888
		|-> blend_out.pixel_out[7:0] == 8'hFF)
		else $error("rgba8888 alpha byte not opaque");

	a_rgb565_upper_clear: assert property (@(posedge clk) disable iff (!arst_n)
		blend_out.valid && blend_out.write_enable && cfg_q.pixel_format == FMT_RGB565
		|-> blend_out.pixel_out[31:16] == 16'd0)
		else $error("rgb565 result has upper bits set");

	a_rgb888_top_clear: assert property (@(posedge clk) disable iff (!arst_n)
		blend_out.valid && blend_out.write_enable && cfg_q.pixel_format == FMT_RGB888
		|-> blend_out.pixel_out[31:24] == 8'd0)
		else $error("rgb888 result has top byte set");
endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import gcb_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [7:0]  glyph;
		logic [2:0]  col;
		logic [31:0] bg;
	} glyph_pixel_t;

	typedef struct packed {
		logic [31:0] pixel;
		logic        write;
	} blend_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	gcb_in_if  glyph_in ();
	gcb_out_if blend_out ();

	glyph_coverage_blend_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.glyph_in  (glyph_in),
		.blend_out (blend_out)
	);

	// shadow copy of the block's registers
	logic [31:0] cur_color;
	cov_mode_t   cur_mode;
	pix_fmt_t    cur_format;

	glyph_pixel_t  pending_pixels[$];
	blend_result_t expected_pixels[$];

	bit          no_idle;
	int unsigned send_gap;
	int unsigned recv_stall;
	int unsigned error_count;
	int unsigned results_seen;
	int unsigned writes_seen;
	int unsigned settings_used;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int unsigned idle_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 30);
	endfunction

	function automatic logic [7:0] channel_mix(input int unsigned fg, input int unsigned bg,
		input int unsigned wgt);
		return 8'((fg * wgt + bg * (255 - wgt)) / 255);
	endfunction

	function automatic blend_result_t blend_pixel(input logic [7:0] glyph, input logic [2:0] col,
		input logic [31:0] bg);
		blend_result_t res;
		int unsigned   ta;
		int unsigned   tr;
		int unsigned   tg;
		int unsigned   tb;
		int unsigned   field;
		int unsigned   cov;
		int unsigned   wgt;
		logic [15:0]   color16;
		logic [31:0]   w5;
		logic [31:0]   bgs;
		logic [31:0]   fgs;
		logic [31:0]   acc;
		ta = 32'(cur_color[7:0]);
		tr = 32'(cur_color[31:24]);
		tg = 32'(cur_color[23:16]);
		tb = 32'(cur_color[15:8]);
		case (cur_mode)
			COV_1BIT: begin
				field = 32'(glyph[col]);
				cov = (field != 0) ? 255 : 0;
			end
			COV_2BIT: begin
				field = 32'((glyph >> {col[1:0], 1'b0}) & 8'h03);
				cov = field * 85;
			end
			COV_4BIT: begin
				field = 32'((glyph >> {col[0], 2'b00}) & 8'h0F);
				cov = field * 17;
			end
			default: begin
				field = 32'(glyph);
				cov = 32'(glyph);
			end
		endcase
		wgt = (cur_mode == COV_1BIT) ? ta : (ta * cov / 255);
		res.pixel = bg;
		res.write = 1'b0;
		if (field != 0 && cur_format != FMT_NONE) begin
			res.write = 1'b1;
			case (cur_format)
				FMT_RGB565: begin
					color16 = 16'(((tr * 31 / 255) << 11) + ((tg * 63 / 255) << 5) + tb * 31 / 255);
					if (cur_mode == COV_1BIT) begin
						res.pixel = {16'd0, color16};
					end else begin
						w5 = (wgt + 4) >> 3;
						bgs = ({16'd0, bg[15:0]} | {bg[15:0], 16'd0}) & Mask565;
						fgs = ({16'd0, color16} | {color16, 16'd0}) & Mask565;
						acc = ((fgs - bgs) * w5) >> 5;
						acc = (acc + bgs) & Mask565;
						res.pixel = {16'd0, acc[31:16] | acc[15:0]};
					end
				end
				FMT_RGB888: begin
					res.pixel = {8'd0, channel_mix(tr, 32'(bg[23:16]), wgt),
						channel_mix(tg, 32'(bg[15:8]), wgt), channel_mix(tb, 32'(bg[7:0]), wgt)};
				end
				default: begin
					res.pixel = {channel_mix(tr, 32'(bg[31:24]), wgt),
						channel_mix(tg, 32'(bg[23:16]), wgt),
						channel_mix(tb, 32'(bg[15:8]), wgt), 8'hFF};
				end
			endcase
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		error_count++;
		$display("mismatch on %s: got %h, expected %h (result %0d)", what, got, want,
			results_seen);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_TEXT_COLOR: cur_color = data;
			REG_COVERAGE_MODE: cur_mode = cov_mode_t'(data[1:0]);
			REG_PIXEL_FORMAT: cur_format = pix_fmt_t'(data[1:0]);
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_blend(input logic [31:0] color, input logic [1:0] mode,
		input logic [1:0] fmt);
		write_reg(REG_TEXT_COLOR, color);
		write_reg(REG_COVERAGE_MODE, {30'($urandom_range(0, 32'h3FFF_FFFF)), mode});
		write_reg(REG_PIXEL_FORMAT, {30'($urandom_range(0, 32'h3FFF_FFFF)), fmt});
		settings_used++;
	endtask

	task automatic add_pixel(input logic [7:0] glyph, input logic [2:0] col,
		input logic [31:0] bg);
		glyph_pixel_t px;
		px.glyph = glyph;
		px.col = col;
		px.bg = bg;
		pending_pixels.push_back(px);
	endtask

	task automatic wait_idle();
		while (pending_pixels.size() != 0 || expected_pixels.size() != 0 || glyph_in.valid)
			@(posedge clk);
	endtask

	// driver: one transfer per accepted pixel, prediction taken at the transfer
	always @(posedge clk or negedge arst_n) begin : drive
		glyph_pixel_t nxt;
		if (!arst_n) begin
			glyph_in.valid <= 1'b0;
			glyph_in.glyph_byte <= '0;
			glyph_in.sub_column <= '0;
			glyph_in.background_pixel <= '0;
			send_gap = 0;
		end else begin
			if (glyph_in.valid && glyph_in.ready)
				expected_pixels.push_back(blend_pixel(glyph_in.glyph_byte, glyph_in.sub_column,
					glyph_in.background_pixel));
			if (!glyph_in.valid || glyph_in.ready) begin
				if (send_gap != 0 || pending_pixels.size() == 0) begin
					glyph_in.valid <= 1'b0;
					if (send_gap != 0)
						send_gap--;
				end else begin
					nxt = pending_pixels.pop_front();
					glyph_in.valid <= 1'b1;
					glyph_in.glyph_byte <= nxt.glyph;
					glyph_in.sub_column <= nxt.col;
					glyph_in.background_pixel <= nxt.bg;
					send_gap = idle_cycles();
				end
			end
		end
	end

	// monitor: compare each result transfer with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : collect
		blend_result_t want;
		if (!arst_n) begin
			blend_out.ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (blend_out.valid && blend_out.ready) begin
				results_seen++;
				if (blend_out.write_enable)
					writes_seen++;
				if (expected_pixels.size() == 0) begin
					report_mismatch("unexpected result", blend_out.pixel_out, 32'd0);
				end else begin
					want = expected_pixels.pop_front();
					if (blend_out.pixel_out !== want.pixel)
						report_mismatch("pixel_out", blend_out.pixel_out, want.pixel);
					if (blend_out.write_enable !== want.write)
						report_mismatch("write_enable", {31'd0, blend_out.write_enable},
							{31'd0, want.write});
				end
			end
			if (recv_stall != 0) begin
				recv_stall--;
				blend_out.ready <= 1'b0;
			end else begin
				blend_out.ready <= 1'b1;
				recv_stall = idle_cycles();
			end
		end
	end

	initial begin : stimulus
		int unsigned pick;
		logic [31:0] color;
		logic [1:0]  mode;
		logic [1:0]  fmt;
		logic [7:0]  glyph;
		logic [31:0] bg;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		glyph_in.valid = 1'b0;
		glyph_in.glyph_byte = '0;
		glyph_in.sub_column = '0;
		glyph_in.background_pixel = '0;
		blend_out.ready = 1'b0;
		no_idle = 1'b0;
		error_count = 0;
		results_seen = 0;
		writes_seen = 0;
		settings_used = 1;
		cur_color = '0;
		cur_mode = COV_8BIT;
		cur_format = FMT_RGB565;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register values after reset
		add_pixel(8'h00, 3'd0, 32'hFFFF_FFFF);
		add_pixel(8'hFF, 3'd7, 32'h0000_0000);
		add_pixel(8'h80, 3'd3, $urandom());
		wait_idle();

		// solid one-bit glyph on rgb565, spare index write ignored
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		set_blend(32'hFFFF_FFFF, COV_1BIT, FMT_RGB565);
		add_pixel(8'h80, 3'd7, $urandom());
		add_pixel(8'h80, 3'd6, $urandom());
		add_pixel(8'h01, 3'd0, 32'hFFFF_FFFF);
		wait_idle();

		// two-bit coverage on rgb888, column wraps
		set_blend(32'h00FF_8080, COV_2BIT, FMT_RGB888);
		add_pixel(8'hC0, 3'd3, $urandom());
		add_pixel(8'h40, 3'd7, $urandom());
		add_pixel(8'h03, 3'd4, $urandom());
		wait_idle();

		// four-bit coverage on rgba8888
		set_blend({24'($urandom_range(0, 32'hFF_FFFF)), 8'hFF}, COV_4BIT, FMT_RGBA8888);
		add_pixel(8'hF0, 3'd1, $urandom());
		add_pixel(8'h0F, 3'd2, $urandom());
		add_pixel(8'h0F, 3'd1, $urandom());
		wait_idle();

		// unassigned format leaves the frame alone
		set_blend(32'h0000_0000, COV_8BIT, FMT_NONE);
		add_pixel(8'hFF, 3'd0, $urandom());
		add_pixel(8'h01, 3'd5, $urandom());
		wait_idle();

		// zero text alpha, rgb565 blend path
		set_blend(32'hFFFF_FF00, COV_2BIT, FMT_RGB565);
		add_pixel(8'hFF, 3'd0, $urandom());
		add_pixel(8'h55, 3'd1, 32'h0000_0000);
		wait_idle();

		// one-bit coverage on rgb888 blends with text alpha
		set_blend($urandom(), COV_1BIT, FMT_RGB888);
		add_pixel(8'hFF, 3'd7, $urandom());
		add_pixel(8'h7F, 3'd7, $urandom());
		wait_idle();

		for (int p = 0; p < 16; p++) begin
			pick = $urandom_range(0, 7);
			color = $urandom();
			if (pick == 0)
				color = 32'h0000_0000;
			else if (pick == 1)
				color = 32'hFFFF_FFFF;
			else if (pick == 2)
				color[7:0] = 8'h00;
			else if (pick == 3)
				color[7:0] = 8'hFF;
			mode = 2'($urandom_range(0, 3));
			fmt = ($urandom_range(0, 7) == 0) ? FMT_NONE : 2'($urandom_range(0, 2));
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_SPARE, $urandom());
			set_blend(color, mode, fmt);
			no_idle = (p % 4 == 3);
			for (int i = 0; i < 50; i++) begin
				pick = $urandom_range(0, 9);
				glyph = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom());
				pick = $urandom_range(0, 9);
				bg = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();
				add_pixel(glyph, 3'($urandom_range(0, 7)), bg);
			end
			// sender holds off until the pipeline has drained
			wait_idle();
		end
		no_idle = 1'b0;

		repeat (10) @(posedge clk);
		if (expected_pixels.size() != 0)
			report_mismatch("results never delivered", 32'(expected_pixels.size()), 32'd0);
		$display("%0d pixels blended under %0d register settings", results_seen, settings_used);
		$display("%0d pixels written, %0d left untouched", writes_seen,
			results_seen - writes_seen);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
